// ----- sv/srjb_pkg.sv -----
// Shared types and codes of the sequence reorder jitter buffer.
// Used by the controller, the datapath and the top level; no dependencies.
package srjb_pkg;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_RANGE  = 2'd3;

  localparam logic [3:0] ST_INSERTED    = 4'd0;
  localparam logic [3:0] ST_EVICTED     = 4'd1;
  localparam logic [3:0] ST_STALE       = 4'd2;
  localparam logic [3:0] ST_DUPLICATE   = 4'd3;
  localparam logic [3:0] ST_POPPED      = 4'd4;
  localparam logic [3:0] ST_EMPTY       = 4'd5;
  localparam logic [3:0] ST_NOT_READY   = 4'd6;
  localparam logic [3:0] ST_FOUND       = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd8;
  localparam logic [3:0] ST_RANGE_ITEM  = 4'd9;
  localparam logic [3:0] ST_RANGE_EMPTY = 4'd10;

  // Where the entry fields of an emitted result come from.
  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_PEND  = 2'd1;
  localparam logic [1:0] SRC_RDATA = 2'd2;

  typedef struct packed {
    logic       load;       // capture the accepted request
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_idx;     // read the slot at the scan index
    logic       k_init;     // start a shift pass
    logic       k_down;     // shift toward slot zero
    logic       lim_fill;   // shift limit is the fill level, else the scan index
    logic       rd_k;       // read the shift source slot
    logic       wr_k;       // write the shifted slot
    logic       wr_new;     // write the pushed entry
    logic       pend_load;
    logic       pend_clr;
    logic       set_last;   // record the released sequence
    logic       cnt_push;
    logic       cnt_drop;
    logic       cnt_pop;
    logic       fill_inc;
    logic       fill_dec;
    logic       emit;
    logic [3:0] emit_status;
    logic       emit_last;
    logic [1:0] emit_src;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       stale;
    logic       fill_zero;
    logic       full;
    logic       idx_end;
    logic       idx_zero;
    logic       lt;
    logic       eq;
    logic       in_range;
    logic       ready;
    logic       k_done;
    logic       pend_valid;
    logic       out_free;
  } ctl_sts_t;

endpackage

// ----- sv/sequence_reorder_jitter_buffer.sv -----
// Top level of the sequence reorder jitter buffer.
// Depends on srjb_pkg, srjb_ctrl, srjb_dp and srjb_ram.
//
//   Channel | Direction | Handshake            | Beat contents
//   in_     | input     | in_valid / in_stall  | mode, sequence, bounds, times, payload
//   out_    | output    | out_valid / out_stall| status, entry, last, occupancy, counters
//   cfg_    | input     | cfg_wr_en            | playout delay in milliseconds
//
// One item at a time. Every slot visit goes through the single slot RAM read port
// (address, then registered data). A push into a full buffer shifts the lower slots down
// after its scan.
// Reset is synchronous and active low; it clears the fill level and counters, and the slots
// need no clearing since only filled slots are ever read.
// A stalled output holds its beat; the controller waits before emitting the next one, and
// a new input beat is taken while the last result of the previous item still waits.
module sequence_reorder_jitter_buffer #(
  parameter int DEPTH         = 32,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_sequence_req,
  input  logic [31:0] in_end_sequence,
  input  logic [63:0] in_arrival_time,
  input  logic [63:0] in_now_time,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_entry_sequence,
  output logic [63:0] out_entry_payload,
  output logic        out_last,
  output logic [5:0]  out_occupancy,
  output logic [31:0] out_received_count,
  output logic [31:0] out_dropped_count,
  output logic [31:0] out_processed_count
);
  import srjb_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // The controller walks the sorted slots; the datapath owns all storage and the result beat.
  srjb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srjb_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_mode             (in_mode),
    .in_sequence_req     (in_sequence_req),
    .in_end_sequence     (in_end_sequence),
    .in_arrival_time     (in_arrival_time),
    .in_now_time         (in_now_time),
    .in_payload          (in_payload),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_entry_sequence  (out_entry_sequence),
    .out_entry_payload   (out_entry_payload),
    .out_last            (out_last),
    .out_occupancy       (out_occupancy),
    .out_received_count  (out_received_count),
    .out_dropped_count   (out_dropped_count),
    .out_processed_count (out_processed_count)
  );

endmodule

// ----- sv/srjb_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
module srjb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/srjb_ctrl.sv -----
// Controller state machine of the jitter buffer: sequences scans, shifts and results.
// Depends on srjb_pkg for the command and status structs and the codes.
module srjb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  srjb_pkg::ctl_sts_t sts,
  output srjb_pkg::ctl_cmd_t cmd
);
  import srjb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_PLACE = 4'd4;
  localparam logic [3:0] S_SHR   = 4'd5;
  localparam logic [3:0] S_SHW   = 4'd6;
  localparam logic [3:0] S_WNEW  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.idx_clr  = 1'b1;
        cmd.pend_clr = 1'b1;
        state_nxt    = S_RD;
        if (sts.mode == MODE_PUSH && sts.stale) begin
          state_nxt = S_DISP;
          if (sts.out_free) begin
            cmd.cnt_push    = 1'b1;
            cmd.cnt_drop    = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_STALE;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (sts.mode == MODE_POP && sts.fill_zero) begin
          state_nxt = S_DISP;
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_EMPTY;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_RD: begin
        if (!sts.idx_end) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          case (sts.mode)
            MODE_PUSH: state_nxt = S_PLACE;
            MODE_LOOKUP: begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NOT_FOUND;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end
            MODE_RANGE: begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = sts.pend_valid ? ST_RANGE_ITEM : ST_RANGE_EMPTY;
                cmd.emit_src    = sts.pend_valid ? SRC_PEND : SRC_ZERO;
                state_nxt       = S_IDLE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        case (sts.mode)
          MODE_PUSH: begin
            if (sts.lt) begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end else if (sts.eq) begin
              if (sts.out_free) begin
                cmd.cnt_push    = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_DUPLICATE;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else begin
              state_nxt = S_PLACE;
            end
          end
          MODE_POP: begin
            if (!sts.ready) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NOT_READY;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else begin
              cmd.pend_load = 1'b1;
              cmd.set_last  = 1'b1;
              cmd.k_init    = 1'b1;
              cmd.k_down    = 1'b1;
              cmd.lim_fill  = 1'b1;
              state_nxt     = S_SHR;
            end
          end
          MODE_LOOKUP: begin
            if (sts.eq) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_FOUND;
                cmd.emit_last   = 1'b1;
                cmd.emit_src    = SRC_RDATA;
                state_nxt       = S_IDLE;
              end
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          default: begin
            if (!sts.in_range) begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end else if (!sts.pend_valid || sts.out_free) begin
              // The held match is known not to be the last one now.
              cmd.emit        = sts.pend_valid;
              cmd.emit_status = ST_RANGE_ITEM;
              cmd.emit_src    = SRC_PEND;
              cmd.pend_load   = 1'b1;
              cmd.idx_inc     = 1'b1;
              state_nxt       = S_RD;
            end
          end
        endcase
      end
      S_PLACE: begin
        if (sts.full) begin
          if (sts.idx_zero) begin
            if (sts.out_free) begin
              cmd.cnt_push    = 1'b1;
              cmd.cnt_drop    = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EVICTED;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end else begin
            cmd.k_init = 1'b1;
            cmd.k_down = 1'b1;
            state_nxt  = S_SHR;
          end
        end else begin
          cmd.k_init = 1'b1;
          state_nxt  = S_SHR;
        end
      end
      S_SHR: begin
        if (sts.k_done) begin
          state_nxt = (sts.mode == MODE_PUSH) ? S_WNEW : S_FIN;
        end else begin
          cmd.rd_k  = 1'b1;
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        cmd.wr_k  = 1'b1;
        state_nxt = S_SHR;
      end
      S_WNEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
          if (sts.mode == MODE_PUSH) begin
            cmd.cnt_push    = 1'b1;
            cmd.cnt_drop    = sts.full;
            cmd.fill_inc    = !sts.full;
            cmd.emit_status = sts.full ? ST_EVICTED : ST_INSERTED;
          end else begin
            cmd.cnt_pop     = 1'b1;
            cmd.fill_dec    = 1'b1;
            cmd.emit_status = ST_POPPED;
            cmd.emit_src    = SRC_PEND;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sv/srjb_dp.sv -----
// Datapath of the jitter buffer: slot RAM, scan and shift counters, counters, result register.
// Depends on srjb_pkg and srjb_ram.
module srjb_dp #(
  parameter int DEPTH         = 32,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_sequence_req,
  input  logic [31:0]        in_end_sequence,
  input  logic [63:0]        in_arrival_time,
  input  logic [63:0]        in_now_time,
  input  logic [63:0]        in_payload,
  input  srjb_pkg::ctl_cmd_t cmd,
  output srjb_pkg::ctl_sts_t sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [3:0]         out_status,
  output logic [31:0]        out_entry_sequence,
  output logic [63:0]        out_entry_payload,
  output logic               out_last,
  output logic [5:0]         out_occupancy,
  output logic [31:0]        out_received_count,
  output logic [31:0]        out_dropped_count,
  output logic [31:0]        out_processed_count
);
  import srjb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 32 + 64 + PAYLOAD_WIDTH;

  logic [15:0]              delay_r;
  logic [1:0]               req_mode_r;
  logic [31:0]              req_seq_r, req_end_r;
  logic [63:0]              req_arr_r, req_now_r;
  logic [PAYLOAD_WIDTH-1:0] req_pay_r;
  logic [CW-1:0]            fill_r, fill_nxt, idx_r, k_r, lim_r, k_m1;
  logic                     dir_down_r;
  logic                     pend_valid_r;
  logic [31:0]              pend_seq_r;
  logic [PAYLOAD_WIDTH-1:0] pend_pay_r;
  logic [31:0]              last_rel_r;
  logic [31:0]              cnt_rx_r, cnt_rx_nxt, cnt_drop_r, cnt_drop_nxt;
  logic [31:0]              cnt_pop_r, cnt_pop_nxt;
  logic                     out_valid_r, out_free;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr, shift_waddr;
  logic [EW-1:0]            ram_wdata, ram_rdata;
  logic [31:0]              rd_seq;
  logic [63:0]              rd_arr;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  assign rd_seq = ram_rdata[EW-1 -: 32];
  assign rd_arr = ram_rdata[PAYLOAD_WIDTH +: 64];
  assign rd_pay = ram_rdata[PAYLOAD_WIDTH-1:0];

  assign k_m1        = k_r - CW'(1);
  assign shift_waddr = dir_down_r ? k_m1[AW-1:0] : k_r[AW-1:0];
  assign ram_re      = cmd.rd_idx | cmd.rd_k;
  assign ram_raddr   = cmd.rd_idx ? idx_r[AW-1:0] :
                       (dir_down_r ? k_r[AW-1:0] : k_m1[AW-1:0]);
  assign ram_we      = cmd.wr_k | cmd.wr_new;
  assign ram_waddr   = shift_waddr;
  assign ram_wdata   = cmd.wr_new ? {req_seq_r, req_arr_r, req_pay_r} : ram_rdata;

  srjb_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    fill_nxt     = fill_r;
    cnt_rx_nxt   = cnt_rx_r;
    cnt_drop_nxt = cnt_drop_r;
    cnt_pop_nxt  = cnt_pop_r;
    if (cmd.fill_inc) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CW'(1);
    end
    if (cmd.cnt_push) begin
      cnt_rx_nxt = cnt_rx_r + 32'd1;
    end
    if (cmd.cnt_drop) begin
      cnt_drop_nxt = cnt_drop_r + 32'd1;
    end
    if (cmd.cnt_pop) begin
      cnt_pop_nxt = cnt_pop_r + 32'd1;
    end
  end

  always_comb begin
    sts            = '0;
    sts.mode       = req_mode_r;
    sts.stale      = (req_seq_r <= last_rel_r);
    sts.fill_zero  = (fill_r == '0);
    sts.full       = (fill_r == CW'(DEPTH));
    sts.idx_end    = (idx_r == fill_r);
    sts.idx_zero   = (idx_r == '0);
    sts.lt         = (rd_seq < req_seq_r);
    sts.eq         = (rd_seq == req_seq_r);
    sts.in_range   = (rd_seq >= req_seq_r) && (rd_seq <= req_end_r);
    sts.ready      = ({1'b0, req_now_r} >= ({1'b0, rd_arr} + 65'(delay_r)));
    sts.k_done     = (k_r == lim_r);
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r      <= '0;
      fill_r       <= '0;
      last_rel_r   <= '0;
      cnt_rx_r     <= '0;
      cnt_drop_r   <= '0;
      cnt_pop_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delay_r <= cfg_wr_data;
      end
      fill_r     <= fill_nxt;
      cnt_rx_r   <= cnt_rx_nxt;
      cnt_drop_r <= cnt_drop_nxt;
      cnt_pop_r  <= cnt_pop_nxt;
      if (cmd.set_last) begin
        last_rel_r <= rd_seq;
      end
      if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_seq_r  <= in_sequence_req;
      req_end_r  <= in_end_sequence;
      req_arr_r  <= in_arrival_time;
      req_now_r  <= in_now_time;
      req_pay_r  <= in_payload[PAYLOAD_WIDTH-1:0];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.k_init) begin
      dir_down_r <= cmd.k_down;
      k_r        <= cmd.k_down ? CW'(1) : fill_r;
      lim_r      <= cmd.lim_fill ? fill_r : idx_r;
    end else if (cmd.wr_k) begin
      k_r <= dir_down_r ? (k_r + CW'(1)) : k_m1;
    end
    if (cmd.pend_load) begin
      pend_seq_r <= rd_seq;
      pend_pay_r <= rd_pay;
    end
    if (cmd.emit) begin
      out_status          <= cmd.emit_status;
      out_last            <= cmd.emit_last;
      out_occupancy       <= 6'(fill_nxt);
      out_received_count  <= cnt_rx_nxt;
      out_dropped_count   <= cnt_drop_nxt;
      out_processed_count <= cnt_pop_nxt;
      case (cmd.emit_src)
        SRC_PEND: begin
          out_entry_sequence <= pend_seq_r;
          out_entry_payload  <= 64'(pend_pay_r);
        end
        SRC_RDATA: begin
          out_entry_sequence <= rd_seq;
          out_entry_payload  <= 64'(rd_pay);
        end
        default: begin
          out_entry_sequence <= '0;
          out_entry_payload  <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill level above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result overwritten while stalled");

  a_fill_moves_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.emit |=> $stable(fill_r))
    else $error("fill level changed without a result");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_k |-> (k_r <= fill_r))
    else $error("shift index beyond fill level");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the sequence reorder jitter buffer.
// Depends on srjb_pkg and sequence_reorder_jitter_buffer; predicts every result beat in-line.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srjb_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] seq;
    logic [63:0] pay;
    logic        last;
    logic [5:0]  occ;
    logic [31:0] rcv;
    logic [31:0] drp;
    logic [31:0] prc;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_PUSH;
  logic [31:0] in_sequence_req = '0;
  logic [31:0] in_end_sequence = '0;
  logic [63:0] in_arrival_time = '0;
  logic [63:0] in_now_time = '0;
  logic [63:0] in_payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [31:0] out_entry_sequence;
  logic [63:0] out_entry_payload;
  logic        out_last;
  logic [5:0]  out_occupancy;
  logic [31:0] out_received_count;
  logic [31:0] out_dropped_count;
  logic [31:0] out_processed_count;

  sequence_reorder_jitter_buffer dut (.*);

  always #6 clk = ~clk;

  // The predictor's view of the buffer, kept sorted by ascending sequence.
  logic [31:0] ord_seq[$];
  logic [63:0] ord_arr[$];
  logic [63:0] ord_pay[$];
  logic [31:0] released_seq;
  logic [31:0] n_pushes, n_drops, n_pops;
  logic [15:0] delay_ms;
  beat_t       pending_beats[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic beat_t make_beat(logic [3:0] st, logic [31:0] s, logic [63:0] p,
                                      logic fin);
    beat_t b;
    b.status = st; b.seq = s; b.pay = p; b.last = fin;
    b.occ = 6'(ord_seq.size());
    b.rcv = n_pushes; b.drp = n_drops; b.prc = n_pops;
    return b;
  endfunction

  // Appends one predicted beat behind the ones still waiting.
  task automatic expect_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  // Works out the result beats of one accepted request and updates the predicted store.
  task automatic predict_request(logic [1:0] m, logic [31:0] s, logic [31:0] e,
                                 logic [63:0] arr, logic [63:0] now, logic [63:0] pay);
    int pos;
    int hits;
    logic [64:0] ready_at;
    logic [31:0] rel_seq;
    logic [63:0] rel_pay;
    pos = 0;
    hits = 0;
    case (m)
      MODE_PUSH: begin
        n_pushes++;
        if (s <= released_seq) begin
          n_drops++;
          expect_beat(make_beat(ST_STALE, '0, '0, 1'b1));
        end else begin
          while (pos < ord_seq.size() && ord_seq[pos] < s) pos++;
          if (pos < ord_seq.size() && ord_seq[pos] == s) begin
            expect_beat(make_beat(ST_DUPLICATE, '0, '0, 1'b1));
          end else if (ord_seq.size() >= SLOTS) begin
            // Full: the lowest of the stored entries and the new one goes.
            n_drops++;
            if (pos != 0) begin
              ord_seq.delete(0); ord_arr.delete(0); ord_pay.delete(0);
              ord_seq.insert(pos - 1, s); ord_arr.insert(pos - 1, arr);
              ord_pay.insert(pos - 1, pay);
            end
            expect_beat(make_beat(ST_EVICTED, '0, '0, 1'b1));
          end else begin
            ord_seq.insert(pos, s); ord_arr.insert(pos, arr); ord_pay.insert(pos, pay);
            expect_beat(make_beat(ST_INSERTED, '0, '0, 1'b1));
          end
        end
      end
      MODE_POP: begin
        if (ord_seq.size() == 0) begin
          expect_beat(make_beat(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          // The ready time is formed one bit wider so that it never wraps.
          ready_at = {1'b0, ord_arr[0]} + 65'(delay_ms);
          if ({1'b0, now} < ready_at) begin
            expect_beat(make_beat(ST_NOT_READY, '0, '0, 1'b1));
          end else begin
            rel_seq = ord_seq[0];
            rel_pay = ord_pay[0];
            released_seq = rel_seq;
            ord_seq.delete(0); ord_arr.delete(0); ord_pay.delete(0);
            n_pops++;
            expect_beat(make_beat(ST_POPPED, rel_seq, rel_pay, 1'b1));
          end
        end
      end
      MODE_LOOKUP: begin
        pos = -1;
        foreach (ord_seq[i]) if (pos < 0 && ord_seq[i] == s) pos = i;
        if (pos >= 0) expect_beat(make_beat(ST_FOUND, ord_seq[pos], ord_pay[pos], 1'b1));
        else expect_beat(make_beat(ST_NOT_FOUND, '0, '0, 1'b1));
      end
      default: begin
        foreach (ord_seq[i]) begin
          if (ord_seq[i] >= s && ord_seq[i] <= e) begin
            expect_beat(make_beat(ST_RANGE_ITEM, ord_seq[i], ord_pay[i], 1'b0));
            hits++;
          end
        end
        if (hits == 0) expect_beat(make_beat(ST_RANGE_EMPTY, '0, '0, 1'b1));
        else pending_beats[pending_beats.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // Offers one request beat, holds it until accepted, and predicts its results.
  // Valid stays high after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_request(logic [1:0] m, logic [31:0] s, logic [31:0] e,
                              logic [63:0] arr, logic [63:0] now, logic [63:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m; in_sequence_req <= s; in_end_sequence <= e;
    in_arrival_time <= arr; in_now_time <= now; in_payload <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(m, s, e, arr, now, pay);
  endtask

  // Waits until every predicted beat has arrived, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_delay(logic [15:0] d);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delay_ms = d;
  endtask

  // Receiver: random stalls, plus a long hold-off counted here when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 2000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Checker: compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_entry_sequence, out_entry_payload, out_last, out_occupancy,
             out_received_count, out_dropped_count, out_processed_count};
      if (pending_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.seq !== want.seq)
          report_mismatch($sformatf("sequence %0h, expected %0h", got.seq, want.seq));
        if (got.pay !== want.pay)
          report_mismatch($sformatf("payload %0h, expected %0h", got.pay, want.pay));
        if (got.last !== want.last) report_mismatch("last flag differs");
        if (got.occ !== want.occ)
          report_mismatch($sformatf("occupancy %0d, expected %0d", got.occ, want.occ));
        if (got.rcv !== want.rcv) report_mismatch("received count differs");
        if (got.drp !== want.drp) report_mismatch("dropped count differs");
        if (got.prc !== want.prc) report_mismatch("processed count differs");
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Extremes of the fields, sequence zero, reversed range, exact ready time, wrap of ready time.
  task automatic test_directed();
    send_request(MODE_POP, 0, 0, 0, '1, 0);
    send_request(MODE_PUSH, 0, 0, 0, 0, '1);
    send_request(MODE_PUSH, 32'hFFFF_FFFF, 0, '1, 0, '1);
    send_request(MODE_PUSH, 5, 0, 100, 0, 64'h5555_AAAA_5555_AAAA);
    send_request(MODE_PUSH, 5, 0, 1, 0, 0);
    send_request(MODE_PUSH, 3, 0, 200, 0, 64'hAAAA_5555_AAAA_5555);
    send_request(MODE_LOOKUP, 5, 0, 0, 0, 0);
    send_request(MODE_LOOKUP, 4, 0, 0, 0, 0);
    send_request(MODE_RANGE, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(MODE_RANGE, 9, 4, 0, 0, 0);
    send_request(MODE_RANGE, 6, 7, 0, 0, 0);
    set_delay(16'hFFFF);
    send_request(MODE_POP, 0, 0, 0, 200 + 65534, 0);
    send_request(MODE_POP, 0, 0, 0, 200 + 65535, 0);
    send_request(MODE_PUSH, 3, 0, 0, 0, 0);
    send_request(MODE_POP, 0, 0, 0, 100 + 65535, 0);
    send_request(MODE_POP, 0, 0, 0, '1, 0);
    send_request(MODE_PUSH, 0, 0, 0, 0, 0);
    send_request(MODE_PUSH, 32'h8000_0000, 0, '1, 0, 1);
    send_request(MODE_POP, 0, 0, 0, '1, 0);
    set_delay(16'd0);
    send_request(MODE_POP, 0, 0, 0, '1, 0);
    send_request(MODE_POP, 0, 0, 0, 0, 0);
  endtask

  // Fills past the capacity, including a new entry lower than all stored ones.
  // The sequences start above the last released one so that none of them is stale.
  task automatic test_overflow();
    logic [31:0] base;
    base = released_seq + 32'h1000;
    for (int i = 0; i < SLOTS + 4; i++)
      send_request(MODE_PUSH, base + 32'(i * 3), 0, 64'(i), 0, rand64());
    send_request(MODE_PUSH, base - 1, 0, 0, 0, rand64());
    send_request(MODE_PUSH, base + 200, 0, 0, 0, rand64());
    send_request(MODE_RANGE, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(MODE_RANGE, base + 20, base + 40, 0, 0, 0);
  endtask

  // Long receiver hold-off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 12; i++) send_request(MODE_RANGE, 0, 32'hFFFF_FFFF, 0, 0, 0);
  endtask

  // Random traffic around a sliding window of sequences, so that hits are frequent.
  task automatic test_random(int count);
    logic [31:0] s;
    logic [1:0]  m;
    logic [63:0] t;
    for (int i = 0; i < count; i++) begin
      s = released_seq + 32'($urandom_range(1, 48));
      if ($urandom_range(19) == 0) s = $urandom();
      if ($urandom_range(9) == 0) s = released_seq - 32'($urandom_range(0, 3));
      m = 2'($urandom_range(3));
      if ($urandom_range(2) == 0) m = MODE_PUSH;
      t = 64'($urandom_range(0, 20000));
      if ($urandom_range(15) == 0) t = rand64();
      send_request(m, s, s + 32'($urandom_range(0, 30)), t,
                   64'($urandom_range(0, 90000)) | ($urandom_range(7) == 0 ? '1 : 64'(0)),
                   rand64());
    end
  endtask

  initial begin
    released_seq = '0; n_pushes = '0; n_drops = '0; n_pops = '0; delay_ms = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    send_idle_pct = 21; recv_idle_pct = 63;
    test_random(120);
    set_delay(16'd1000);
    send_idle_pct = 63; recv_idle_pct = 21;
    test_random(120);
    set_delay(16'd7);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(120);
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end
endmodule
